>>> rtl/circle_circle_intersection_defines.svh
// Assertion macros for the circle intersection block.
// Included by the top level; no other dependencies.
`ifndef CIRCLE_CIRCLE_INTERSECTION_DEFINES_SVH
`define CIRCLE_CIRCLE_INTERSECTION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CCI_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define CCI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CCI_ASSERT(label, clk, rstn, prop, msg)
`define CCI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

>>> rtl/cci_pkg.sv
// Shared constants and types for the circle intersection pipeline.
// No dependencies; imported by cci_mul and the top level.
package cci_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    // Bits of the multiplier operand consumed per pipeline stage.
    localparam int MUL_DIGIT = 16;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_CONC = 2'd2
    } status_t;

endpackage

>>> rtl/cci_delay.sv
// Sideband delay line with valid bits, used to keep side data aligned with
// the arithmetic units. No package dependencies.
module cci_delay #(
    parameter int DW    = 1,
    parameter int DEPTH = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          vld_in,
    input  logic [DW-1:0] data_in,
    output logic          vld_out,
    output logic [DW-1:0] data_out
);

    logic [DEPTH-1:0] vld_reg;
    logic [DW-1:0]    data_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg[0] <= vld_in;
            for (int k = 1; k < DEPTH; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg[0] <= data_in;
            for (int k = 1; k < DEPTH; k++) begin
                data_reg[k] <= data_reg[k-1];
            end
        end
    end

    assign vld_out  = vld_reg[DEPTH-1];
    assign data_out = data_reg[DEPTH-1];

endmodule

>>> rtl/cci_mul.sv
// Pipelined unsigned multiplier: one MUL_DIGIT-bit slice of b per stage.
// Depends on cci_pkg for the slice width.
module cci_mul import cci_pkg::*; #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    localparam int LAT = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BP  = LAT * MUL_DIGIT;
    localparam int PW  = AW + BW;
    localparam int XW  = AW + MUL_DIGIT;

    logic [AW-1:0] a_reg   [LAT-1];
    logic [BP-1:0] b_reg   [LAT-1];
    logic [PW-1:0] acc_reg [LAT];

    for (genvar k = 0; k < LAT; k++) begin : g_stage
        logic [AW-1:0] a_in;
        logic [BP-1:0] b_in;
        logic [PW-1:0] acc_in;
        logic [XW-1:0] pp;

        if (k == 0) begin : g_first
            assign a_in   = a;
            assign b_in   = BP'(b);
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = a_reg[k-1];
            assign b_in   = b_reg[k-1];
            assign acc_in = acc_reg[k-1];
        end

        assign pp = XW'(a_in) * XW'(b_in[k*MUL_DIGIT +: MUL_DIGIT]);

        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[k] <= acc_in + (PW'(pp) << (k * MUL_DIGIT));
            end
        end

        if (k < LAT - 1) begin : g_fwd
            always_ff @(posedge aclk) begin
                if (en) begin
                    a_reg[k] <= a_in;
                    b_reg[k] <= b_in;
                end
            end
        end
    end

    assign p = acc_reg[LAT-1];

endmodule

>>> rtl/cci_sqrt.sv
// Pipelined integer square root (floor), one result bit per stage.
// No package dependencies.
module cci_sqrt #(
    parameter int IW = 131
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [IW-1:0]        x,
    output logic [(IW+1)/2-1:0]  root
);

    localparam int RW = (IW + 1) / 2;
    localparam int XW = IW + 2;

    logic [XW-1:0] rem_reg  [RW-1];
    logic [RW-1:0] root_reg [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int BI = RW - 1 - k;
        logic [XW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [XW-1:0] term;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in  = XW'(x);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // Growing root r by 2^i costs 2*r*2^i + 4^i of the remainder.
        assign term = (XW'(root_in) << (BI + 1)) + (XW'(1) << (2 * BI));
        assign take = (rem_in >= term);

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= take ? (root_in | (RW'(1) << BI)) : root_in;
            end
        end

        if (k < RW - 1) begin : g_fwd
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= take ? (rem_in - term) : rem_in;
                end
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

>>> rtl/cci_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// The numerator must be below d shifted up by QB. No package dependencies.
module cci_div #(
    parameter int DW = 67,
    parameter int QB = 34
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [DW+QB-1:0] n,
    input  logic [DW-1:0]    d,
    output logic [QB-1:0]    q
);

    localparam int NW = DW + QB;

    logic [NW-1:0] rem_reg [QB-1];
    logic [DW-1:0] d_reg   [QB-1];
    logic [QB-1:0] q_reg   [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int BI = QB - 1 - k;
        logic [NW-1:0] rem_in;
        logic [DW-1:0] d_in;
        logic [QB-1:0] q_in;
        logic [NW-1:0] sub;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in = n;
            assign d_in   = d;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign sub  = NW'(d_in) << BI;
        assign take = (rem_in >= sub);

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k] <= take ? (q_in | (QB'(1) << BI)) : q_in;
            end
        end

        if (k < QB - 1) begin : g_fwd
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= take ? (rem_in - sub) : rem_in;
                    d_reg[k]   <= d_in;
                end
            end
        end
    end

    assign q = q_reg[QB-1];

endmodule

>>> rtl/circle_circle_intersection.sv
// Top level of the two-circle intersection pipeline.
// Uses cci_pkg, cci_delay, cci_mul, cci_sqrt, cci_div and the assertion macros.
//
//   channel   ports                                  handshake
//   input     s_center_a_x .. s_radius_b             s_valid / s_ready
//   result    m_point1_x .. m_point2_y, m_status     m_valid / m_ready
//
// One request enters per cycle while s_ready is high. The square root and the
// division each resolve one bit per stage. Reset clears all valid bits; payload
// registers are not reset. A stall at the output freezes every stage; s_ready
// follows the output register.
`include "circle_circle_intersection_defines.svh"

module circle_circle_intersection import cci_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [COORD_WIDTH-1:0] s_center_a_x,
    input  logic [COORD_WIDTH-1:0] s_center_a_y,
    input  logic [COORD_WIDTH-2:0] s_radius_a,
    input  logic [COORD_WIDTH-1:0] s_center_b_x,
    input  logic [COORD_WIDTH-1:0] s_center_b_y,
    input  logic [COORD_WIDTH-2:0] s_radius_b,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COORD_WIDTH-1:0] m_point1_x,
    output logic [COORD_WIDTH-1:0] m_point1_y,
    output logic [COORD_WIDTH-1:0] m_point2_x,
    output logic [COORD_WIDTH-1:0] m_point2_y,
    output logic [1:0]             m_status
);

    localparam int W    = COORD_WIDTH;
    localparam int EW   = W + 1;          // center difference and its magnitude
    localparam int PRW  = 2 * EW;         // squares and d2
    localparam int STW  = 2 * W - 1;      // s*t
    localparam int PQW  = 2 * W + 1;      // s^2 - d2
    localparam int QW   = PRW;            // d2 - t^2
    localparam int IW   = PQW + QW;       // radicand
    localparam int RW   = (IW + 1) / 2;   // root
    localparam int G3W  = RW + EW;        // numerators
    localparam int DVW  = PRW + 1;        // 2*d2
    localparam int QB   = W + 2;          // quotient bits
    localparam int NW   = DVW + QB;
    localparam int SUMW = QB + 3;
    localparam int L1   = (EW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int L2   = (QW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int SB1  = 4 * EW + 4;
    localparam int SB2  = SB1 + PRW + STW + 2;
    localparam int SB3  = 2 * EW + 4 + PRW + 2;
    localparam int SB4  = 2 * EW + 4 + 2;

    logic en;

    // ---------------- input register
    logic          s0_vld_reg;
    logic [W-1:0]  s0_ax_reg, s0_ay_reg, s0_bx_reg, s0_by_reg;
    logic [W-2:0]  s0_ra_reg, s0_rb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (en) begin
            s0_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_ax_reg <= s_center_a_x;
            s0_ay_reg <= s_center_a_y;
            s0_ra_reg <= s_radius_a;
            s0_bx_reg <= s_center_b_x;
            s0_by_reg <= s_center_b_y;
            s0_rb_reg <= s_radius_b;
        end
    end

    // ---------------- stage 1: differences, sums, signs
    logic [EW-1:0] dx_c, dy_c, ux_c, uy_c, sumx_c, sumy_c;
    logic [W-1:0]  s_c;
    logic [W-2:0]  t_c;

    assign dx_c   = {s0_bx_reg[W-1], s0_bx_reg} - {s0_ax_reg[W-1], s0_ax_reg};
    assign dy_c   = {s0_by_reg[W-1], s0_by_reg} - {s0_ay_reg[W-1], s0_ay_reg};
    assign ux_c   = dx_c[EW-1] ? (~dx_c + EW'(1)) : dx_c;
    assign uy_c   = dy_c[EW-1] ? (~dy_c + EW'(1)) : dy_c;
    assign sumx_c = {s0_ax_reg[W-1], s0_ax_reg} + {s0_bx_reg[W-1], s0_bx_reg};
    assign sumy_c = {s0_ay_reg[W-1], s0_ay_reg} + {s0_by_reg[W-1], s0_by_reg};
    assign s_c    = W'(s0_ra_reg) + W'(s0_rb_reg);
    assign t_c    = (s0_ra_reg > s0_rb_reg) ? (s0_ra_reg - s0_rb_reg)
                                            : (s0_rb_reg - s0_ra_reg);

    logic          s1_vld_reg;
    logic [EW-1:0] s1_ux_reg, s1_uy_reg, s1_sumx_reg, s1_sumy_reg;
    logic [W-1:0]  s1_s_reg;
    logic [W-2:0]  s1_t_reg;
    logic [3:0]    s1_flags_reg;   // {dneg, dxneg, dyneg, dxpos}

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ux_reg    <= ux_c;
            s1_uy_reg    <= uy_c;
            s1_sumx_reg  <= sumx_c;
            s1_sumy_reg  <= sumy_c;
            s1_s_reg     <= s_c;
            s1_t_reg     <= t_c;
            s1_flags_reg <= {s0_ra_reg < s0_rb_reg, dx_c[EW-1], dy_c[EW-1],
                             !dx_c[EW-1] && (dx_c != '0)};
        end
    end

    // ---------------- multiply group 1: squares and s*t
    logic [PRW-1:0] dx2_p, dy2_p, s2_p, t2_p, st_p;

    cci_mul #(.AW(EW), .BW(EW)) u_mul_dx2 (
        .aclk(aclk), .en(en), .a(s1_ux_reg), .b(s1_ux_reg), .p(dx2_p));
    cci_mul #(.AW(EW), .BW(EW)) u_mul_dy2 (
        .aclk(aclk), .en(en), .a(s1_uy_reg), .b(s1_uy_reg), .p(dy2_p));
    cci_mul #(.AW(EW), .BW(EW)) u_mul_s2 (
        .aclk(aclk), .en(en), .a(EW'(s1_s_reg)), .b(EW'(s1_s_reg)), .p(s2_p));
    cci_mul #(.AW(EW), .BW(EW)) u_mul_t2 (
        .aclk(aclk), .en(en), .a(EW'(s1_t_reg)), .b(EW'(s1_t_reg)), .p(t2_p));
    cci_mul #(.AW(EW), .BW(EW)) u_mul_st (
        .aclk(aclk), .en(en), .a(EW'(s1_s_reg)), .b(EW'(s1_t_reg)), .p(st_p));

    logic           g1_vld;
    logic [SB1-1:0] g1_sb;

    cci_delay #(.DW(SB1), .DEPTH(L1)) u_dly_g1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(s1_vld_reg),
        .data_in({s1_sumx_reg, s1_sumy_reg, s1_ux_reg, s1_uy_reg, s1_flags_reg}),
        .vld_out(g1_vld), .data_out(g1_sb));

    // ---------------- stage 2: d2, status, radicand factors
    logic [PRW-1:0] d2_c;
    status_t        status_c;

    assign d2_c = dx2_p + dy2_p;

    always_comb begin
        if (d2_c == '0) begin
            status_c = STATUS_CONC;
        end else if ((s2_p < d2_c) || (d2_c < t2_p)) begin
            status_c = STATUS_MISS;
        end else begin
            status_c = STATUS_OK;
        end
    end

    logic           s2_vld_reg;
    logic [PQW-1:0] s2_p_reg;
    logic [QW-1:0]  s2_q_reg;
    logic [PRW-1:0] s2_d2_reg;
    logic [STW-1:0] s2_st_reg;
    status_t        s2_status_reg;
    logic [SB1-1:0] s2_sb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= g1_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_p_reg      <= PQW'(s2_p - d2_c);
            s2_q_reg      <= d2_c - t2_p;
            s2_d2_reg     <= d2_c;
            s2_st_reg     <= STW'(st_p);
            s2_status_reg <= status_c;
            s2_sb_reg     <= g1_sb;
        end
    end

    // ---------------- radicand product and square root
    logic [IW-1:0] pq_p;
    logic [RW-1:0] root;

    cci_mul #(.AW(PQW), .BW(QW)) u_mul_pq (
        .aclk(aclk), .en(en), .a(s2_p_reg), .b(s2_q_reg), .p(pq_p));

    cci_sqrt #(.IW(IW)) u_sqrt (
        .aclk(aclk), .en(en), .x(pq_p), .root(root));

    logic           g2_vld;
    logic [SB2-1:0] g2_sb;

    cci_delay #(.DW(SB2), .DEPTH(L2 + RW)) u_dly_g2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(s2_vld_reg),
        .data_in({s2_sb_reg, s2_d2_reg, s2_st_reg, s2_status_reg}),
        .vld_out(g2_vld), .data_out(g2_sb));

    logic [EW-1:0]  g2_sumx, g2_sumy, g2_ux, g2_uy;
    logic [3:0]     g2_flags;
    logic [PRW-1:0] g2_d2;
    logic [STW-1:0] g2_st;
    logic [1:0]     g2_status;

    assign {g2_sumx, g2_sumy, g2_ux, g2_uy, g2_flags, g2_d2, g2_st, g2_status} = g2_sb;

    // ---------------- multiply group 3: numerators
    logic [G3W-1:0] n_shx_p, n_shy_p, n_ofx_p, n_ofy_p;

    cci_mul #(.AW(RW), .BW(EW)) u_mul_shx (
        .aclk(aclk), .en(en), .a(RW'(g2_st)), .b(g2_ux), .p(n_shx_p));
    cci_mul #(.AW(RW), .BW(EW)) u_mul_shy (
        .aclk(aclk), .en(en), .a(RW'(g2_st)), .b(g2_uy), .p(n_shy_p));
    cci_mul #(.AW(RW), .BW(EW)) u_mul_ofx (
        .aclk(aclk), .en(en), .a(root), .b(g2_uy), .p(n_ofx_p));
    cci_mul #(.AW(RW), .BW(EW)) u_mul_ofy (
        .aclk(aclk), .en(en), .a(root), .b(g2_ux), .p(n_ofy_p));

    logic           g3_vld;
    logic [SB3-1:0] g3_sb;

    cci_delay #(.DW(SB3), .DEPTH(L1)) u_dly_g3 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(g2_vld),
        .data_in({g2_sumx, g2_sumy, g2_flags, g2_d2, g2_status}),
        .vld_out(g3_vld), .data_out(g3_sb));

    logic [EW-1:0]  g3_sumx, g3_sumy;
    logic [3:0]     g3_flags;
    logic [PRW-1:0] g3_d2;
    logic [1:0]     g3_status;

    assign {g3_sumx, g3_sumy, g3_flags, g3_d2, g3_status} = g3_sb;

    // ---------------- stage 3: rounding bias and divisor
    logic           s3_vld_reg;
    logic [NW-1:0]  s3_n_shx_reg, s3_n_shy_reg, s3_n_ofx_reg, s3_n_ofy_reg;
    logic [DVW-1:0] s3_div_reg;
    logic [SB4-1:0] s3_sb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (en) begin
            s3_vld_reg <= g3_vld;
        end
    end

    // Adding d2 before dividing by 2*d2 rounds half away from zero on magnitudes.
    always_ff @(posedge aclk) begin
        if (en) begin
            s3_n_shx_reg <= NW'(n_shx_p) + NW'(g3_d2);
            s3_n_shy_reg <= NW'(n_shy_p) + NW'(g3_d2);
            s3_n_ofx_reg <= NW'(n_ofx_p) + NW'(g3_d2);
            s3_n_ofy_reg <= NW'(n_ofy_p) + NW'(g3_d2);
            s3_div_reg   <= {g3_d2, 1'b0};
            s3_sb_reg    <= {g3_sumx, g3_sumy, g3_flags, g3_status};
        end
    end

    // ---------------- dividers
    logic [QB-1:0] q_shx, q_shy, q_ofx, q_ofy;

    cci_div #(.DW(DVW), .QB(QB)) u_div_shx (
        .aclk(aclk), .en(en), .n(s3_n_shx_reg), .d(s3_div_reg), .q(q_shx));
    cci_div #(.DW(DVW), .QB(QB)) u_div_shy (
        .aclk(aclk), .en(en), .n(s3_n_shy_reg), .d(s3_div_reg), .q(q_shy));
    cci_div #(.DW(DVW), .QB(QB)) u_div_ofx (
        .aclk(aclk), .en(en), .n(s3_n_ofx_reg), .d(s3_div_reg), .q(q_ofx));
    cci_div #(.DW(DVW), .QB(QB)) u_div_ofy (
        .aclk(aclk), .en(en), .n(s3_n_ofy_reg), .d(s3_div_reg), .q(q_ofy));

    logic           g4_vld;
    logic [SB4-1:0] g4_sb;

    cci_delay #(.DW(SB4), .DEPTH(QB)) u_dly_g4 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(s3_vld_reg),
        .data_in(s3_sb_reg), .vld_out(g4_vld), .data_out(g4_sb));

    logic [EW-1:0] g4_sumx, g4_sumy;
    logic          g4_dneg, g4_dxneg, g4_dyneg, g4_dxpos;
    status_t       g4_status;

    assign {g4_sumx, g4_sumy, g4_dneg, g4_dxneg, g4_dyneg, g4_dxpos} = g4_sb[SB4-1:2];
    assign g4_status = status_t'(g4_sb[1:0]);

    // ---------------- final sums and saturation
    function automatic logic [SUMW-1:0] apply_sign(input logic [QB-1:0] mag,
                                                   input logic neg);
        logic [SUMW-1:0] v;
        v = SUMW'(mag);
        return neg ? (~v + SUMW'(1)) : v;
    endfunction

    function automatic logic [W-1:0] saturate(input logic [SUMW-1:0] v);
        logic [SUMW-W:0] hi;
        hi = v[SUMW-1:W-1];
        if ((&hi) || !(|hi)) begin
            return v[W-1:0];
        end else if (v[SUMW-1]) begin
            return {1'b1, {(W-1){1'b0}}};
        end else begin
            return {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    logic [SUMW-1:0] mx_c, my_c, shx_c, shy_c, ofx_c, ofy_c;
    logic [W-1:0]    p1x_c, p1y_c, p2x_c, p2y_c;

    // Dropping the low bit of the center sum is a floor halving.
    assign mx_c  = {{(SUMW-W){g4_sumx[EW-1]}}, g4_sumx[EW-1:1]};
    assign my_c  = {{(SUMW-W){g4_sumy[EW-1]}}, g4_sumy[EW-1:1]};
    assign shx_c = apply_sign(q_shx, g4_dneg ^ g4_dxneg);
    assign shy_c = apply_sign(q_shy, g4_dneg ^ g4_dyneg);
    assign ofx_c = apply_sign(q_ofx, g4_dyneg);
    assign ofy_c = apply_sign(q_ofy, g4_dxpos);

    always_comb begin
        if (g4_status == STATUS_OK) begin
            p1x_c = saturate(mx_c + shx_c + ofx_c);
            p1y_c = saturate(my_c + shy_c + ofy_c);
            p2x_c = saturate(mx_c + shx_c - ofx_c);
            p2y_c = saturate(my_c + shy_c - ofy_c);
        end else begin
            p1x_c = '0;
            p1y_c = '0;
            p2x_c = '0;
            p2y_c = '0;
        end
    end

    // ---------------- output register
    logic         m_valid_reg;
    logic [W-1:0] m_p1x_reg, m_p1y_reg, m_p2x_reg, m_p2y_reg;
    status_t      m_status_reg;

    assign en = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= g4_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_p1x_reg    <= p1x_c;
            m_p1y_reg    <= p1y_c;
            m_p2x_reg    <= p2x_c;
            m_p2y_reg    <= p2y_c;
            m_status_reg <= g4_status;
        end
    end

    assign s_ready    = en;
    assign m_valid    = m_valid_reg;
    assign m_point1_x = m_p1x_reg;
    assign m_point1_y = m_p1y_reg;
    assign m_point2_x = m_p2x_reg;
    assign m_point2_y = m_p2y_reg;
    assign m_status   = m_status_reg;

    // ---------------- assertions
    `CCI_ASSERT(a_fail_zero, aclk, aresetn, !(m_valid && (m_status_reg != STATUS_OK)) || ((m_point1_x == '0) && (m_point1_y == '0) && (m_point2_x == '0) && (m_point2_y == '0)), "failed request carries nonzero points")
    `CCI_ASSERT_NEXT(a_in_capture, aclk, aresetn, s_valid && s_ready, s0_vld_reg, "accepted request missing from input stage")
    `CCI_ASSERT_NEXT(a_stall_hold, aclk, aresetn, !en, $stable(s1_vld_reg) && $stable(s2_vld_reg) && $stable(s3_vld_reg), "pipeline advanced during a stall")
    `CCI_ASSERT(a_reset_clear, aclk, aresetn, !$past(aresetn) |-> !m_valid, "result valid right after reset")

endmodule
